@@ hw/rtl/hfd_pkg.sv @@
// hfd_pkg: shared types, constants and the prefix code table of the text frame decoder
// no dependencies
`timescale 1ns / 1ps

package hfd_pkg;

    localparam int HEAD_W      = 8;
    localparam int TAIL_W      = 64;
    localparam int FRAME_BITS  = HEAD_W + TAIL_W;
    localparam int CHAR_W      = 7;
    localparam int NUM_SYMBOLS = 44;

    localparam logic [6:0] LAST_BIT       = 7'd71;
    localparam logic [6:0] FIRST_DATA_BIT = 7'd2;
    localparam logic [6:0] FRAME_LEN      = 7'd72;
    localparam logic [6:0] MAX_CHARS      = 7'd47;
    localparam logic [6:0] UNKNOWN_CHAR   = 7'd63;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SRCH,
        ST_DEC
    } t_state;

    // one table lookup: code length (0 when nothing matches) and character
    typedef struct packed {
        logic [3:0]        len;
        logic [CHAR_W-1:0] ascii;
    } t_sym;

    localparam logic [7:0] CODE_PAT [NUM_SYMBOLS] = '{
        8'd1,   8'd4,   8'd13,  8'd3,   8'd31,  8'd28,  8'd23,  8'd20,
        8'd3,   8'd0,   8'd59,  8'd51,  8'd49,  8'd45,  8'd43,  8'd11,
        8'd9,   8'd5,   8'd3,   8'd123, 8'd121, 8'd116, 8'd101, 8'd100,
        8'd97,  8'd96,  8'd89,  8'd88,  8'd85,  8'd84,  8'd21,  8'd20,
        8'd17,  8'd16,  8'd9,   8'd8,   8'd5,   8'd4,   8'd245, 8'd244,
        8'd241, 8'd240, 8'd235, 8'd234
    };

    localparam logic [3:0] CODE_LEN [NUM_SYMBOLS] = '{
        4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5,
        4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8,
        4'd8, 4'd8, 4'd8, 4'd8
    };

    // ' ' E T A O I N S H R D L C U M W F G Y P B . V K - + ? ! " X 0 J 1 Q 2 Z 3 5 4 9 8 6 7 /
    localparam logic [CHAR_W-1:0] CODE_ASC [NUM_SYMBOLS] = '{
        7'd32, 7'd69, 7'd84, 7'd65, 7'd79, 7'd73, 7'd78, 7'd83,
        7'd72, 7'd82, 7'd68, 7'd76, 7'd67, 7'd85, 7'd77, 7'd87,
        7'd70, 7'd71, 7'd89, 7'd80, 7'd66, 7'd46, 7'd86, 7'd75,
        7'd45, 7'd43, 7'd63, 7'd33, 7'd34, 7'd88, 7'd48, 7'd74,
        7'd49, 7'd81, 7'd50, 7'd90, 7'd51, 7'd53, 7'd52, 7'd57,
        7'd56, 7'd54, 7'd55, 7'd47
    };

    // 8-bit window, first bit as msb; a constant 256-entry table after synthesis
    function automatic t_sym code_lookup(input logic [7:0] win);
        t_sym res;
        logic hit;
        res.len   = 4'd0;
        res.ascii = UNKNOWN_CHAR;
        hit       = 1'b0;
        for (int s = 0; s < NUM_SYMBOLS; s++) begin
            if (!hit && ((win >> (4'd8 - CODE_LEN[s])) == CODE_PAT[s])) begin
                hit       = 1'b1;
                res.len   = CODE_LEN[s];
                res.ascii = CODE_ASC[s];
            end
        end
        return res;
    endfunction

    // count of ones from bit 0 upward before the first zero, looking at bits 0 to 6 only
    function automatic logic [2:0] trail_ones(input logic [7:0] v);
        logic [2:0] cnt;
        logic       stop;
        cnt  = 3'd0;
        stop = 1'b0;
        for (int i = 0; i < 7; i++) begin
            if (!stop && v[i]) begin
                cnt = cnt + 3'd1;
            end else begin
                stop = 1'b1;
            end
        end
        return cnt;
    endfunction

endpackage

@@ hw/rtl/hfd_in_if.sv @@
// hfd_in_if: frame input channel, valid/ready with frame payload
// depends on hfd_pkg
`timescale 1ns / 1ps

interface hfd_in_if;
    logic                      valid;
    logic                      ready;
    logic [hfd_pkg::HEAD_W-1:0] frame_head;
    logic [hfd_pkg::TAIL_W-1:0] frame_tail;
    logic                      over_bit;

    modport source (output valid, output frame_head, output frame_tail, output over_bit,
                    input ready);
    modport sink   (input valid, input frame_head, input frame_tail, input over_bit,
                    output ready);
endinterface

@@ hw/rtl/hfd_out_if.sv @@
// hfd_out_if: character output channel, valid/ready with one decoded item
// depends on hfd_pkg
`timescale 1ns / 1ps

interface hfd_out_if;
    logic                       valid;
    logic                       ready;
    logic [hfd_pkg::CHAR_W-1:0] char_code;
    logic                       char_valid;
    logic                       end_of_over;
    logic                       last;

    modport source (output valid, output char_code, output char_valid, output end_of_over,
                    output last, input ready);
    modport sink   (input valid, input char_code, input char_valid, input end_of_over,
                    input last, output ready);
endinterface

@@ hw/rtl/huffman_text_frame_decoder_unit.sv @@
// huffman_text_frame_decoder_unit: static prefix code decoder for 72-bit text frames
// depends on hfd_pkg, hfd_in_if, hfd_out_if
`timescale 1ns / 1ps

// Usage
//   i_in  : one frame per transaction (frame_head = bits 0..7, frame_tail = bits 8..71,
//           over_bit = end-of-over marker). Ready is high only while the block is idle.
//   o_out : one transaction per decoded character (char_valid = 1), then one closing
//           transaction (last = 1, char_valid = 0, end_of_over = over_bit).
// Timing
//   padding search: eight frame bits per cycle, through a shared trailing-ones unit on a
//   shifting search register; the first character is issued after the search ends.
//   decode: one character per cycle while the receiver does not stall, from a single code
//   lookup and barrel shift of the frame register, then the closing transaction.
// Reset
//   synchronous active-low reset returns to idle and drops output valid.
// Back-pressure
//   results sit in one output register; while the receiver stalls, decoding pauses and
//   the waiting transaction holds. A new frame is taken while the closing item still waits.
module huffman_text_frame_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hfd_in_if.sink      i_in,
    hfd_out_if.source   o_out
);

    hfd_pkg::t_state r_state, n_state;

    logic [hfd_pkg::FRAME_BITS-1:0] r_srch, n_srch;
    logic [hfd_pkg::FRAME_BITS-1:0] r_data, n_data;
    logic [6:0]                     r_cnt,  n_cnt;
    logic [6:0]                     r_pos,  n_pos;
    logic [6:0]                     r_end,  n_end;
    logic                           r_over, n_over;

    logic                           r_ov,   n_ov;
    logic [hfd_pkg::CHAR_W-1:0]     r_code, n_code;
    logic                           r_cv,   n_cv;
    logic                           r_eoo,  n_eoo;
    logic                           r_last, n_last;

    logic [hfd_pkg::FRAME_BITS-1:0] w_frame;
    logic                           w_accept;
    logic                           w_free;
    logic                           w_go;
    logic                           w_all_ones;
    logic [6:0]                     w_cnt8;
    logic [6:0]                     w_zpos;
    hfd_pkg::t_sym                  w_sym;
    logic                           w_fit;
    logic [3:0]                     w_adv;
    logic [hfd_pkg::CHAR_W-1:0]     w_char;

    assign w_frame    = {i_in.frame_head, i_in.frame_tail};
    assign w_accept   = i_in.valid && (r_state == hfd_pkg::ST_IDLE);
    assign w_free     = !r_ov || o_out.ready;
    assign w_go       = (r_pos < r_end) && (r_cnt < hfd_pkg::MAX_CHARS);

    // search unit: eight bits of the reversed frame per cycle
    assign w_all_ones = &r_srch[7:0];
    assign w_cnt8     = r_cnt + 7'd8;
    assign w_zpos     = hfd_pkg::LAST_BIT - (r_cnt + {4'd0, hfd_pkg::trail_ones(r_srch[7:0])});

    // decode unit: code lookup on the top window, a code may not run past the frame
    assign w_sym  = hfd_pkg::code_lookup(r_data[hfd_pkg::FRAME_BITS-1 -: 8]);
    assign w_fit  = (w_sym.len != 4'd0) &&
                    (({1'b0, r_pos} + {4'd0, w_sym.len}) <= {1'b0, hfd_pkg::FRAME_LEN});
    assign w_adv  = w_fit ? w_sym.len : 4'd1;
    assign w_char = w_fit ? w_sym.ascii : hfd_pkg::UNKNOWN_CHAR;

    assign i_in.ready        = (r_state == hfd_pkg::ST_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.char_code   = r_code;
    assign o_out.char_valid  = r_cv;
    assign o_out.end_of_over = r_eoo;
    assign o_out.last        = r_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hfd_pkg::ST_IDLE: begin
                if (w_accept) n_state = hfd_pkg::ST_SRCH;
            end
            hfd_pkg::ST_SRCH: begin
                if (!w_all_ones || (w_cnt8 == hfd_pkg::FRAME_LEN)) n_state = hfd_pkg::ST_DEC;
            end
            hfd_pkg::ST_DEC: begin
                if (w_free && !w_go) n_state = hfd_pkg::ST_IDLE;
            end
            default: n_state = hfd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_srch = r_srch;
        n_data = r_data;
        n_cnt  = r_cnt;
        n_pos  = r_pos;
        n_end  = r_end;
        n_over = r_over;
        n_ov   = r_ov;
        n_code = r_code;
        n_cv   = r_cv;
        n_eoo  = r_eoo;
        n_last = r_last;
        if (o_out.ready) n_ov = 1'b0;
        unique case (r_state)
            hfd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    // fill bit of ones at the top; the search ends when the chunk count reaches the frame length
                    n_srch = {1'b1, w_frame[hfd_pkg::FRAME_BITS-2:0]};
                    n_data = {w_frame[hfd_pkg::FRAME_BITS-3:0], 2'b00};
                    n_cnt  = 7'd0;
                    n_pos  = hfd_pkg::FIRST_DATA_BIT;
                    n_over = i_in.over_bit;
                end
            end
            hfd_pkg::ST_SRCH: begin
                if (w_all_ones) begin
                    n_srch = {8'hFF, r_srch[hfd_pkg::FRAME_BITS-1:8]};
                    if (w_cnt8 == hfd_pkg::FRAME_LEN) begin
                        n_end = 7'd0;
                        n_cnt = 7'd0;
                    end else begin
                        n_cnt = w_cnt8;
                    end
                end else begin
                    n_end = w_zpos;
                    n_cnt = 7'd0;
                end
            end
            hfd_pkg::ST_DEC: begin
                if (w_free) begin
                    n_ov = 1'b1;
                    if (w_go) begin
                        n_code = w_char;
                        n_cv   = 1'b1;
                        n_eoo  = 1'b0;
                        n_last = 1'b0;
                        n_data = r_data << w_adv;
                        n_pos  = r_pos + {3'd0, w_adv};
                        n_cnt  = r_cnt + 7'd1;
                    end else begin
                        n_code = '0;
                        n_cv   = 1'b0;
                        n_eoo  = r_over;
                        n_last = 1'b1;
                    end
                end
            end
            default: begin
                n_ov = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hfd_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_srch <= n_srch;
        r_data <= n_data;
        r_cnt  <= n_cnt;
        r_pos  <= n_pos;
        r_end  <= n_end;
        r_over <= n_over;
        r_code <= n_code;
        r_cv   <= n_cv;
        r_eoo  <= n_eoo;
        r_last <= n_last;
    end

endmodule

@@ hw/rtl/hfd_checker.sv @@
// hfd_checker: port-level assertions for huffman_text_frame_decoder_unit
// depends on the top level's ports only, attached by bind
`timescale 1ns / 1ps

module hfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_char_code,
    input logic       i_char_valid,
    input logic       i_end_of_over,
    input logic       i_last
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_char_code) && $stable(i_last) &&
         $stable(i_end_of_over) && $stable(i_char_valid)))
        else $error("stalled output transaction changed");

    // block is busy right after taking a frame
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a frame transaction");

    // closing item carries no character
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_last) |-> (!i_char_valid && (i_char_code == 7'd0)))
        else $error("closing item carries a character");

    // character items are never closing and never flag end of over
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_last) |-> (i_char_valid && !i_end_of_over &&
                                      (i_char_code != 7'd0)))
        else $error("malformed character item");

endmodule

bind huffman_text_frame_decoder_unit hfd_checker u_hfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_char_code   (o_out.char_code),
    .i_char_valid  (o_out.char_valid),
    .i_end_of_over (o_out.end_of_over),
    .i_last        (o_out.last)
);
